// ===== src/icf_pkg.sv =====
// Shared types, constants and the CORDIC arctangent table for the complementary filter.
`default_nettype none
package icf_pkg;

    localparam int XW        = 34;   // CORDIC x/y datapath width
    localparam int ZW        = 28;   // CORDIC angle width, Q.24
    localparam int BW        = 30;   // serial multiplier coefficient width
    localparam int PW        = XW + BW;
    localparam int VW        = 48;   // blend value width, Q.28
    localparam int TABLE_LEN = 24;

    localparam logic signed [ZW-1:0] PI_Q24     = 28'sd52707179;
    localparam logic signed [VW-1:0] PI_Q28     = 48'sd843314857;
    localparam logic signed [VW-1:0] TWO_PI_Q28 = 48'sd1686629713;
    localparam logic [BW-1:0]        INV_GAIN   = 30'd652032874;

    localparam logic [1:0] REG_BLEND_WEIGHT  = 2'd0;
    localparam logic [1:0] REG_SAMPLE_PERIOD = 2'd1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROLL,
        S_ROLL_WAIT,
        S_GAIN,
        S_GAIN_WAIT,
        S_PITCH,
        S_PITCH_WAIT,
        S_RATE,
        S_RATE_WAIT,
        S_GYRO,
        S_GYRO_WAIT,
        S_ACC,
        S_ACC_WAIT,
        S_FIN,
        S_OUT
    } icf_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } icf_unit_status_t;

    function automatic logic signed [ZW-1:0] atan_q24(input logic [4:0] idx);
        logic signed [ZW-1:0] r;
        case (idx)
            5'd0:    r = 28'sd13176795;
            5'd1:    r = 28'sd7778716;
            5'd2:    r = 28'sd4110060;
            5'd3:    r = 28'sd2086331;
            5'd4:    r = 28'sd1047214;
            5'd5:    r = 28'sd524117;
            5'd6:    r = 28'sd262123;
            5'd7:    r = 28'sd131069;
            5'd8:    r = 28'sd65536;
            5'd9:    r = 28'sd32768;
            5'd10:   r = 28'sd16384;
            5'd11:   r = 28'sd8192;
            5'd12:   r = 28'sd4096;
            5'd13:   r = 28'sd2048;
            5'd14:   r = 28'sd1024;
            5'd15:   r = 28'sd512;
            5'd16:   r = 28'sd256;
            5'd17:   r = 28'sd128;
            5'd18:   r = 28'sd64;
            5'd19:   r = 28'sd32;
            5'd20:   r = 28'sd16;
            5'd21:   r = 28'sd8;
            5'd22:   r = 28'sd4;
            5'd23:   r = 28'sd2;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== src/icf_sermul.sv =====
// Bit-serial shift-add multiplier: signed multiplicand, unsigned coefficient, one bit per cycle.
`default_nettype none
module icf_sermul
    import icf_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic signed [XW-1:0] a,
    input  wire logic [BW-1:0]        b,
    output icf_unit_status_t          status,
    output logic signed [PW-1:0]      prod
);
    localparam int CW = $clog2(BW + 1);

    logic signed [PW-1:0] acc_reg, acc_next;
    logic signed [PW-1:0] ash_reg, ash_next;
    logic [BW-1:0]        bsh_reg, bsh_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    always_comb
    begin
        acc_next  = acc_reg;
        ash_next  = ash_reg;
        bsh_next  = bsh_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = '0;
            ash_next  = {{BW{a[XW-1]}}, a};
            bsh_next  = b;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (bsh_reg[0])
            begin
                acc_next = acc_reg + ash_reg;
            end
            ash_next = ash_reg <<< 1;
            bsh_next = bsh_reg >> 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(BW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        ash_reg <= ash_next;
        bsh_reg <= bsh_next;
    end

    assign prod        = acc_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule
`default_nettype wire

// ===== src/icf_cordic.sv =====
// Iterative vectoring CORDIC: atan2 and gain-scaled magnitude, one micro-rotation per cycle.
`default_nettype none
module icf_cordic
    import icf_pkg::*;
#(
    parameter int STEPS = 16
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic signed [XW-1:0] x_in,
    input  wire logic signed [XW-1:0] y_in,
    output icf_unit_status_t          status,
    output logic signed [ZW-1:0]      ang,
    output logic signed [XW-1:0]      mag
);
    localparam int N = (STEPS > TABLE_LEN) ? TABLE_LEN : STEPS;

    logic signed [XW-1:0] x_reg, x_next;
    logic signed [XW-1:0] y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic                 zero_reg, zero_next;
    logic [4:0]           i_reg, i_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic signed [XW-1:0] xs, ys;

    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        zero_next = zero_reg;
        i_next    = i_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        xs        = x_reg >>> i_reg;
        ys        = y_reg >>> i_reg;
        if (start)
        begin
            zero_next = (x_in == '0) && (y_in == '0);
            i_next    = '0;
            busy_next = 1'b1;
            if (x_in[XW-1])
            begin
                z_next = y_in[XW-1] ? -PI_Q24 : PI_Q24;
                x_next = -x_in;
                y_next = -y_in;
            end
            else
            begin
                z_next = '0;
                x_next = x_in;
                y_next = y_in;
            end
        end
        else if (busy_reg)
        begin
            if (!y_reg[XW-1])
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + atan_q24(i_reg);
            end
            else
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - atan_q24(i_reg);
            end
            i_next = i_reg + 1'b1;
            if (i_reg == 5'(N - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            i_reg    <= i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        zero_reg <= zero_next;
    end

    assign ang         = zero_reg ? '0 : z_reg;
    assign mag         = zero_reg ? '0 : x_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule
`default_nettype wire

// ===== src/imu_complementary_filter_core.sv =====
// Top level of the roll/pitch complementary filter: sequencer, blend datapath, config, output.
//
//  channel  | dir | handshake         | payload
//  s_*      | in  | s_tvalid/s_tready | s_tdata[79:0] IMU sample item
//  m_*      | out | m_tvalid/m_tready | m_tdata[31:0] roll/pitch item
//  cfg_*    | in  | cfg_we            | cfg_addr[1:0], cfg_wdata[15:0]
//
// Each item runs two CORDIC passes of min(CORDIC_STEPS,24) micro-rotations (one micro-rotation
// a cycle plus start and capture) and seven serial multiplies (30 shift-add steps plus start
// and capture).
// Items are processed one at a time; s_tready is high only while the sequencer idles.
// A finished result waits in the output register while the next item is accepted.
// Reset clears roll and pitch estimates and loads the default registers.
`default_nettype none
module imu_complementary_filter_core
    import icf_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,   // accel_x, accel_y, accel_z, rate_x, rate_y
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // roll_angle, pitch_angle
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata
);
    icf_state_t state_reg, state_next;

    logic [15:0]          alpha_reg, dt_reg;
    logic signed [15:0]   ax_reg, ay_reg, az_reg, rx_reg, ry_reg;
    logic signed [15:0]   roll_est_reg, pitch_est_reg;
    logic signed [ZW-1:0] roll_acc_reg, pitch_acc_reg;
    logic signed [XW-1:0] mag_reg, rd_reg;
    logic signed [PW-1:0] p1_reg, p2_reg;
    logic                 axis_reg;
    logic                 m_tvalid_reg;
    logic [31:0]          m_tdata_reg;

    logic                 cor_start, mul_start, load_out;
    logic signed [XW-1:0] cor_x, cor_y, mul_a;
    logic [BW-1:0]        mul_b;
    icf_unit_status_t     cor_st, mul_st;
    logic signed [ZW-1:0] cor_ang;
    logic signed [XW-1:0] cor_mag;
    logic signed [PW-1:0] mul_prod, gain_rnd, sum;
    logic signed [15:0]   est_sel, rate_sel;
    logic signed [ZW-1:0] acc_sel;
    logic signed [XW-1:0] gyro;
    logic signed [VW-1:0] v0, v1, v2, vr;
    logic signed [15:0]   est_new;

    icf_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cor_start),
        .x_in   (cor_x),
        .y_in   (cor_y),
        .status (cor_st),
        .ang    (cor_ang),
        .mag    (cor_mag)
    );

    icf_sermul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .status (mul_st),
        .prod   (mul_prod)
    );

    assign est_sel  = axis_reg ? pitch_est_reg : roll_est_reg;
    assign rate_sel = axis_reg ? ry_reg : rx_reg;
    assign acc_sel  = axis_reg ? pitch_acc_reg : roll_acc_reg;
    assign gyro     = (XW'(est_sel) <<< 15) + rd_reg;
    assign gain_rnd = mul_prod + (PW'(1) <<< 29);

    assign sum = p1_reg + p2_reg + (PW'(1) <<< 15);
    assign v0  = sum[PW-1:16];
    assign v1  = (v0 > PI_Q28) ? (v0 - TWO_PI_Q28) : v0;
    assign v2  = (v1 < -PI_Q28) ? (v1 + TWO_PI_Q28) : v1;
    assign vr  = (v2 + (VW'(1) <<< 14)) >>> 15;

    always_comb
    begin
        if (vr > VW'(32767))
        begin
            est_new = 16'sh7FFF;
        end
        else if (vr < -VW'(32768))
        begin
            est_new = -16'sh8000;
        end
        else
        begin
            est_new = vr[15:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cor_start  = 1'b0;
        mul_start  = 1'b0;
        load_out   = 1'b0;
        cor_x      = XW'(az_reg) <<< 14;
        cor_y      = XW'(ay_reg) <<< 14;
        mul_a      = mag_reg;
        mul_b      = INV_GAIN;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_ROLL;
                end
            end
            S_ROLL:
            begin
                cor_start  = 1'b1;
                state_next = S_ROLL_WAIT;
            end
            S_ROLL_WAIT:
            begin
                if (cor_st.done)
                begin
                    state_next = S_GAIN;
                end
            end
            S_GAIN:
            begin
                mul_a      = cor_mag;
                mul_start  = 1'b1;
                state_next = S_GAIN_WAIT;
            end
            S_GAIN_WAIT:
            begin
                if (mul_st.done)
                begin
                    state_next = S_PITCH;
                end
            end
            S_PITCH:
            begin
                cor_x      = mag_reg;
                cor_y      = -(XW'(ax_reg) <<< 14);
                cor_start  = 1'b1;
                state_next = S_PITCH_WAIT;
            end
            S_PITCH_WAIT:
            begin
                if (cor_st.done)
                begin
                    state_next = S_RATE;
                end
            end
            S_RATE:
            begin
                mul_a      = XW'(rate_sel);
                mul_b      = BW'(dt_reg);
                mul_start  = 1'b1;
                state_next = S_RATE_WAIT;
            end
            S_RATE_WAIT:
            begin
                if (mul_st.done)
                begin
                    state_next = S_GYRO;
                end
            end
            S_GYRO:
            begin
                mul_a      = gyro;
                mul_b      = BW'(alpha_reg);
                mul_start  = 1'b1;
                state_next = S_GYRO_WAIT;
            end
            S_GYRO_WAIT:
            begin
                if (mul_st.done)
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                mul_a      = XW'(acc_sel) <<< 4;
                mul_b      = BW'(17'h10000 - {1'b0, alpha_reg});
                mul_start  = 1'b1;
                state_next = S_ACC_WAIT;
            end
            S_ACC_WAIT:
            begin
                if (mul_st.done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                state_next = axis_reg ? S_OUT : S_RATE;
            end
            S_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            alpha_reg     <= 16'd64225;
            dt_reg        <= 16'd655;
            roll_est_reg  <= '0;
            pitch_est_reg <= '0;
            axis_reg      <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_BLEND_WEIGHT:  alpha_reg <= cfg_wdata;
                    REG_SAMPLE_PERIOD: dt_reg    <= cfg_wdata;
                    default:           ;
                endcase
            end
            if (state_reg == S_IDLE)
            begin
                axis_reg <= 1'b0;
            end
            if (state_reg == S_FIN)
            begin
                if (axis_reg)
                begin
                    pitch_est_reg <= est_new;
                end
                else
                begin
                    roll_est_reg <= est_new;
                end
                axis_reg <= ~axis_reg;
            end
            if (load_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            ax_reg <= s_tdata[15:0];
            ay_reg <= s_tdata[31:16];
            az_reg <= s_tdata[47:32];
            rx_reg <= s_tdata[63:48];
            ry_reg <= s_tdata[79:64];
        end
        if (state_reg == S_ROLL_WAIT && cor_st.done)
        begin
            roll_acc_reg <= cor_ang;
        end
        if (state_reg == S_GAIN_WAIT && mul_st.done)
        begin
            mag_reg <= gain_rnd[XW+29:30];
        end
        if (state_reg == S_PITCH_WAIT && cor_st.done)
        begin
            pitch_acc_reg <= cor_ang;
        end
        if (state_reg == S_RATE_WAIT && mul_st.done)
        begin
            rd_reg <= mul_prod[XW-1:0];
        end
        if (state_reg == S_GYRO_WAIT && mul_st.done)
        begin
            p1_reg <= mul_prod;
        end
        if (state_reg == S_ACC_WAIT && mul_st.done)
        begin
            p2_reg <= mul_prod;
        end
        if (load_out)
        begin
            m_tdata_reg <= {pitch_est_reg, roll_est_reg};
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_idle_units: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (!cor_st.busy && !mul_st.busy))
        else $error("units busy while idle");

    a_mul_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        mul_start |-> (!mul_st.busy && !cor_st.busy))
        else $error("multiplier started while a unit is busy");

    a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !load_out)
        else $error("pending result overwritten");

endmodule
`default_nettype wire
